[rtl/core/sm3_pkg.sv]
// ----------------------------------------------------------------------------
// SM3 hash engine package
// Shared types, constants and round helper functions.
// ----------------------------------------------------------------------------
package sm3_pkg;

   localparam int WordWidth = 32;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DATA,
      ST_PAD,
      ST_LEN,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

   // Source of the byte shifted into the block buffer
   typedef enum logic [1:0] {
      SRC_DATA,
      SRC_PAD80,
      SRC_ZERO,
      SRC_LEN
   } byte_src_type;

   // Controller to datapath commands
   typedef struct packed {
      logic         load_item;
      logic         put_byte;
      byte_src_type byte_src;
      logic [2:0]   byte_idx;
      logic         count_len;
      logic         load_work;
      logic         round;
      logic [5:0]   round_idx;
      logic         fold;
      logic [2:0]   emit_idx;
      logic         finish;
   } cmd_type;

   localparam logic [7:0][31:0] SM3_IV = {
      32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
      32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f
   };

   localparam logic [31:0] T_LOW       = 32'h79cc4519;
   // rotl(0x7a879d8a, 16), the round constant as first used in round 16
   localparam logic [31:0] T_HIGH_ROT  = 32'h9d8a7a87;
   localparam logic [7:0]  PAD_BYTE    = 8'h80;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int k);
      rotl = (x << k) | (x >> (32 - k));
   endfunction

   function automatic logic [31:0] perm0(input logic [31:0] x);
      perm0 = x ^ rotl(x, 9) ^ rotl(x, 17);
   endfunction

   function automatic logic [31:0] perm1(input logic [31:0] x);
      perm1 = x ^ rotl(x, 15) ^ rotl(x, 23);
   endfunction

endpackage

[rtl/core/sm3_stream_if.sv]
// ----------------------------------------------------------------------------
// SM3 stream interfaces
// Valid/ready channels for message items and digest items.
// ----------------------------------------------------------------------------
interface sm3_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] message_word;
   logic [2:0]  valid_bytes;
   logic        last_chunk;

   modport source (output valid, message_word, valid_bytes, last_chunk, input ready);
   modport sink   (input valid, message_word, valid_bytes, last_chunk, output ready);
endinterface

interface sm3_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

[rtl/core/sm3_hash_engine.sv]
// ----------------------------------------------------------------------------
// SM3 hash engine
// Streaming SM3 digest over big-endian message words.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries message items: message_word, valid_bytes (0..4, values
//   above 4 count as 4) and last_chunk. Bytes are packed one per cycle
//   while no block is compressed. Each full 64-byte block is compressed in a
//   load step, 64 rounds of the shared round unit (one round per cycle) and
//   a chain fold step. An item is latched in the idle state; its valid bytes
//   are packed next; a full block is compressed before packing goes on.
//   A last item adds the 0x80 pad, zeros and the 8-byte bit length, one
//   byte per cycle between its one or two compressions, then eight rsp_ch
//   items (digest words 0..7, last_word on word 7), one per cycle while taken.
//   req_ch.ready is high only while the engine is idle. A stalled receiver
//   holds the current digest word; no input is taken until all eight are
//   delivered. Reset returns the chain to the IV and clears the length.
// ----------------------------------------------------------------------------
module sm3_hash_engine (
   input  logic      clock,
   input  logic      reset,
   sm3_req_if.sink   req_ch,
   sm3_rsp_if.source rsp_ch
);

   sm3_pkg::cmd_type cmd;

   sm3_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_valid_bytes (req_ch.valid_bytes),
      .req_last        (req_ch.last_chunk),
      .req_ready       (req_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .cmd             (cmd)
   );

   sm3_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .message_word (req_ch.message_word),
      .digest_word  (rsp_ch.digest_word)
   );

   assign rsp_ch.word_index = cmd.emit_idx;
   assign rsp_ch.last_word  = (cmd.emit_idx == 3'd7);

   // input and output never open together
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("ready and result valid both high");

   // final digest word taken returns engine to idle
   a_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && rsp_ch.last_word) |=> req_ch.ready)
      else $error("not idle after last digest word");

   // an empty non-final item is absorbed at once
   a_empty: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.valid_bytes == 3'd0
       && !req_ch.last_chunk) |=> req_ch.ready)
      else $error("empty item not absorbed");

endmodule

[rtl/core/sm3_ctrl.sv]
// ----------------------------------------------------------------------------
// SM3 controller
// Sequences byte packing, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module sm3_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [2:0]       req_valid_bytes,
   input  logic             req_last,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sm3_pkg::cmd_type cmd
);

   sm3_pkg::state_type state_ff, state_in, ret_ff, ret_in;
   logic [2:0] rem_ff, rem_in;
   logic [1:0] bidx_ff, bidx_in;
   logic       last_ff, last_in;
   logic       sent80_ff, sent80_in;
   logic [5:0] fill_ff, fill_in;
   logic [2:0] lidx_ff, lidx_in;
   logic [5:0] round_ff, round_in;
   logic [2:0] eidx_ff, eidx_in;
   logic [2:0] nb_clamp;
   logic       fill_end;

   // counts above four act as four
   assign nb_clamp = (req_valid_bytes > 3'd4) ? 3'd4 : req_valid_bytes;
   assign fill_end = (fill_ff == 6'd63);

   // next state
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      unique case (state_ff)
         sm3_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (nb_clamp != 3'd0) state_in = sm3_pkg::ST_DATA;
               else if (req_last)    state_in = sm3_pkg::ST_PAD;
            end
         end
         sm3_pkg::ST_DATA: begin
            if (fill_end) begin
               state_in = sm3_pkg::ST_LOAD;
               if (rem_ff != 3'd1) ret_in = sm3_pkg::ST_DATA;
               else if (last_ff)   ret_in = sm3_pkg::ST_PAD;
               else                ret_in = sm3_pkg::ST_IDLE;
            end else if (rem_ff == 3'd1) begin
               state_in = last_ff ? sm3_pkg::ST_PAD : sm3_pkg::ST_IDLE;
            end
         end
         sm3_pkg::ST_PAD: begin
            if (fill_end) begin
               state_in = sm3_pkg::ST_LOAD;
               ret_in   = sm3_pkg::ST_PAD;
            end else if (fill_ff == 6'd55) begin
               state_in = sm3_pkg::ST_LEN;
            end
         end
         sm3_pkg::ST_LEN: begin
            if (fill_end) begin
               state_in = sm3_pkg::ST_LOAD;
               ret_in   = sm3_pkg::ST_EMIT;
            end
         end
         sm3_pkg::ST_LOAD:  state_in = sm3_pkg::ST_ROUND;
         sm3_pkg::ST_ROUND: if (round_ff == 6'd63) state_in = sm3_pkg::ST_FOLD;
         sm3_pkg::ST_FOLD:  state_in = ret_ff;
         sm3_pkg::ST_EMIT:  if (rsp_ready && eidx_ff == 3'd7) state_in = sm3_pkg::ST_IDLE;
         default:           state_in = sm3_pkg::ST_IDLE;
      endcase
   end

   // counters
   always_comb begin
      rem_in    = rem_ff;
      bidx_in   = bidx_ff;
      last_in   = last_ff;
      sent80_in = sent80_ff;
      fill_in   = fill_ff;
      lidx_in   = lidx_ff;
      round_in  = round_ff;
      eidx_in   = eidx_ff;
      unique case (state_ff)
         sm3_pkg::ST_IDLE: begin
            if (req_valid) begin
               rem_in    = nb_clamp;
               bidx_in   = 2'd0;
               last_in   = req_last;
               sent80_in = 1'b0;
               lidx_in   = 3'd0;
               eidx_in   = 3'd0;
            end
         end
         sm3_pkg::ST_DATA: begin
            rem_in  = rem_ff - 3'd1;
            bidx_in = bidx_ff + 2'd1;
            fill_in = fill_ff + 6'd1;
         end
         sm3_pkg::ST_PAD: begin
            sent80_in = 1'b1;
            fill_in   = fill_ff + 6'd1;
         end
         sm3_pkg::ST_LEN: begin
            lidx_in = lidx_ff + 3'd1;
            fill_in = fill_ff + 6'd1;
         end
         sm3_pkg::ST_LOAD:  round_in = 6'd0;
         sm3_pkg::ST_ROUND: round_in = round_ff + 6'd1;
         sm3_pkg::ST_FOLD:  ;
         sm3_pkg::ST_EMIT:  if (rsp_ready) eidx_in = eidx_ff + 3'd1;
         default:           ;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      cmd.round_idx = round_ff;
      cmd.emit_idx  = eidx_ff;
      unique case (state_ff)
         sm3_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         sm3_pkg::ST_DATA: begin
            cmd.put_byte  = 1'b1;
            cmd.byte_src  = sm3_pkg::SRC_DATA;
            cmd.byte_idx  = {1'b0, bidx_ff};
            cmd.count_len = 1'b1;
         end
         sm3_pkg::ST_PAD: begin
            cmd.put_byte = 1'b1;
            cmd.byte_src = sent80_ff ? sm3_pkg::SRC_ZERO : sm3_pkg::SRC_PAD80;
         end
         sm3_pkg::ST_LEN: begin
            cmd.put_byte = 1'b1;
            cmd.byte_src = sm3_pkg::SRC_LEN;
            cmd.byte_idx = lidx_ff;
         end
         sm3_pkg::ST_LOAD:  cmd.load_work = 1'b1;
         sm3_pkg::ST_ROUND: cmd.round = 1'b1;
         sm3_pkg::ST_FOLD:  cmd.fold = 1'b1;
         sm3_pkg::ST_EMIT: begin
            rsp_valid  = 1'b1;
            cmd.finish = rsp_ready && (eidx_ff == 3'd7);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sm3_pkg::ST_IDLE;
         ret_ff    <= sm3_pkg::ST_IDLE;
         rem_ff    <= 3'd0;
         bidx_ff   <= 2'd0;
         last_ff   <= 1'b0;
         sent80_ff <= 1'b0;
         fill_ff   <= 6'd0;
         lidx_ff   <= 3'd0;
         round_ff  <= 6'd0;
         eidx_ff   <= 3'd0;
      end else begin
         state_ff  <= state_in;
         ret_ff    <= ret_in;
         rem_ff    <= rem_in;
         bidx_ff   <= bidx_in;
         last_ff   <= last_in;
         sent80_ff <= sent80_in;
         fill_ff   <= fill_in;
         lidx_ff   <= lidx_in;
         round_ff  <= round_in;
         eidx_ff   <= eidx_in;
      end
   end

endmodule

[rtl/core/sm3_datapath.sv]
// ----------------------------------------------------------------------------
// SM3 datapath
// Block buffer, expansion window, one compression round per cycle, chain.
// ----------------------------------------------------------------------------
module sm3_datapath (
   input  logic             clock,
   input  logic             reset,
   input  sm3_pkg::cmd_type cmd,
   input  logic [31:0]      message_word,
   output logic [31:0]      digest_word
);

   logic [31:0]      word_ff;
   logic [511:0]     block_ff;
   logic [15:0][31:0] win_ff;
   logic [7:0][31:0] work_ff;
   logic [7:0][31:0] chain_ff;
   logic [60:0]      len_ff;
   logic [31:0]      tj_ff;
   logic [7:0]       byte_val;
   logic [63:0]      len_bits;
   logic [63:0]      len_sh;
   logic [31:0]      w_new, a12, ss1, ss2, tt1, tt2, ff_v, gg_v;
   logic             early;

   // byte to shift into the block
   assign len_bits = {len_ff, 3'b000};
   assign len_sh   = len_bits >> {~cmd.byte_idx, 3'b000};
   always_comb begin
      unique case (cmd.byte_src)
         sm3_pkg::SRC_DATA: begin
            unique case (cmd.byte_idx[1:0])
               2'd0: byte_val = word_ff[31:24];
               2'd1: byte_val = word_ff[23:16];
               2'd2: byte_val = word_ff[15:8];
               default: byte_val = word_ff[7:0];
            endcase
         end
         sm3_pkg::SRC_PAD80: byte_val = sm3_pkg::PAD_BYTE;
         sm3_pkg::SRC_ZERO:  byte_val = 8'h00;
         default:            byte_val = len_sh[7:0];
      endcase
   end

   // message expansion: window slot 0 holds W[j]
   assign w_new = sm3_pkg::perm1(win_ff[0] ^ win_ff[7] ^ sm3_pkg::rotl(win_ff[13], 15))
                ^ sm3_pkg::rotl(win_ff[3], 7) ^ win_ff[10];

   // compression round
   assign early = (cmd.round_idx < 6'd16);
   assign a12   = sm3_pkg::rotl(work_ff[0], 12);
   assign ss1   = sm3_pkg::rotl(a12 + work_ff[4] + tj_ff, 7);
   assign ss2   = ss1 ^ a12;
   assign ff_v  = early ? (work_ff[0] ^ work_ff[1] ^ work_ff[2])
                        : ((work_ff[0] & work_ff[1]) | (work_ff[0] & work_ff[2])
                           | (work_ff[1] & work_ff[2]));
   assign gg_v  = early ? (work_ff[4] ^ work_ff[5] ^ work_ff[6])
                        : ((work_ff[4] & work_ff[5]) | (~work_ff[4] & work_ff[6]));
   assign tt1   = ff_v + work_ff[3] + ss2 + (win_ff[0] ^ win_ff[4]);
   assign tt2   = gg_v + work_ff[7] + ss1 + win_ff[0];

   assign digest_word = chain_ff[cmd.emit_idx];

   // item latch, block buffer, window, round constant
   always_ff @(posedge clock) begin
      if (cmd.load_item) word_ff <= message_word;
      if (cmd.put_byte)  block_ff <= {block_ff[503:0], byte_val};
      if (cmd.load_work) begin
         for (int k = 0; k < 16; k++) win_ff[k] <= block_ff[511 - 32 * k -: 32];
         tj_ff <= sm3_pkg::T_LOW;
      end else if (cmd.round) begin
         win_ff <= {w_new, win_ff[15:1]};
         tj_ff  <= (cmd.round_idx == 6'd15) ? sm3_pkg::T_HIGH_ROT
                                             : sm3_pkg::rotl(tj_ff, 1);
      end
   end

   // working registers, chain value, length
   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff  <= '0;
         chain_ff <= sm3_pkg::SM3_IV;
         len_ff   <= '0;
      end else begin
         if (cmd.load_work) begin
            work_ff <= chain_ff;
         end else if (cmd.round) begin
            work_ff[0] <= tt1;
            work_ff[1] <= work_ff[0];
            work_ff[2] <= sm3_pkg::rotl(work_ff[1], 9);
            work_ff[3] <= work_ff[2];
            work_ff[4] <= sm3_pkg::perm0(tt2);
            work_ff[5] <= work_ff[4];
            work_ff[6] <= sm3_pkg::rotl(work_ff[5], 19);
            work_ff[7] <= work_ff[6];
         end
         if (cmd.fold)        chain_ff <= chain_ff ^ work_ff;
         else if (cmd.finish) chain_ff <= sm3_pkg::SM3_IV;
         if (cmd.count_len)   len_ff <= len_ff + 61'd1;
         else if (cmd.finish) len_ff <= '0;
      end
   end

endmodule
